@@ sv/rpg_pkg.sv @@
// shared types and constants of the run-length planar rgb to gray converter
package rpg_pkg;

    localparam int RUN_W     = 7;
    localparam int VAL_W     = 8;
    localparam int CFG_W     = 10;
    localparam int GRAY_W    = 8;
    localparam int SUM_W     = 9;
    localparam int TOT_W     = 10;
    localparam int RECIP_W   = 11;
    localparam int RECIP_SH  = 11;
    localparam int PROD_W    = TOT_W + RECIP_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = 2;
    localparam int FIFO_CW   = 3;
    localparam int CFG_IDX_W = 1;

    // 683 / 2048 gives exact floor(x / 3) for every x below 2048
    localparam logic [RECIP_W-1:0] RECIP_3 = 11'd683;

    localparam logic [CFG_W-1:0] SIZE_RST = 10'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] PLANE_RED   = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_BLUE  = 2'd2;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [RUN_W-1:0] rest;
    } t_cmd;

    typedef struct packed {
        logic credit;
    } t_sts;

    typedef struct packed {
        logic              frame_done;
        logic              run_done;
        logic [GRAY_W-1:0] gray;
    } t_res;

endpackage

@@ sv/rpg_ram.sv @@
// generic single-write, single-read ram with registered read data
module rpg_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 262144
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rpg_ctrl.sv @@
// run controller: accepts one run request and steps its pixels through the datapath
module rpg_ctrl #(
    parameter int MAX_RUN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [rpg_pkg::RUN_W-1:0]  i_run_length,
    input  rpg_pkg::t_sts              i_sts,
    output rpg_pkg::t_cmd              o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [rpg_pkg::RUN_W-1:0] RUN_MAX = rpg_pkg::RUN_W'(MAX_RUN);

    logic                      r_state;
    logic                      n_state;
    logic [rpg_pkg::RUN_W-1:0] r_left;
    logic [rpg_pkg::RUN_W-1:0] n_left;
    logic [rpg_pkg::RUN_W-1:0] len_c;
    logic                      accept;
    logic                      step;

    assign len_c      = (i_run_length > RUN_MAX) ? RUN_MAX : i_run_length;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign step       = (r_state == ST_RUN) && i_sts.credit;

    always_comb begin
        o_cmd.load = accept;
        o_cmd.step = step;
        o_cmd.rest = r_left - rpg_pkg::RUN_W'(1);
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            ST_IDLE: begin
                // a zero-length run is taken and dropped
                if (accept && (len_c != '0)) begin
                    n_state = ST_RUN;
                    n_left  = len_c;
                end
            end
            ST_RUN: begin
                if (step) begin
                    n_left = r_left - rpg_pkg::RUN_W'(1);
                    if (r_left == rpg_pkg::RUN_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

@@ sv/rpg_dp.sv @@
// datapath: position counters, partial-sum read-modify-write, divide by three, result fifo
module rpg_dp #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [rpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpg_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [rpg_pkg::VAL_W-1:0]      i_run_value,
    input  rpg_pkg::t_cmd                  i_cmd,
    output rpg_pkg::t_sts                  o_sts,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output rpg_pkg::t_res                  o_res
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZB   = $clog2(MXD + 1);
    localparam int SZW   = (SZB > rpg_pkg::CFG_W) ? SZB : rpg_pkg::CFG_W;
    localparam int PRW   = 2 * SZW;
    localparam int PW    = $clog2(DEPTH + 1) + 1;
    localparam int CMPW  = (PW > rpg_pkg::RUN_W) ? PW : rpg_pkg::RUN_W;

    function automatic logic [SZW-1:0] clamp_size(input logic [rpg_pkg::CFG_W-1:0] v,
                                                  input logic [SZW-1:0] mx);
        logic [SZW-1:0] ve;
        ve = SZW'(v);
        if (ve == '0) begin
            return SZW'(1);
        end else if (ve > mx) begin
            return mx;
        end
        return ve;
    endfunction

    localparam logic [SZW-1:0] W_MAX = SZW'(MAX_WIDTH);
    localparam logic [SZW-1:0] H_MAX = SZW'(MAX_HEIGHT);

    // size registers (clamped on write)
    logic [SZW-1:0] r_w;
    logic [SZW-1:0] r_h;
    logic [PW-1:0]  r_wh2;
    logic [PRW-1:0] wh;

    // position
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [1:0]     r_plane;
    logic [rpg_pkg::VAL_W-1:0] r_val;

    logic [SZW-1:0] col_inc;
    logic [SZW-1:0] row_inc;
    logic           col_wrap;
    logic           row_wrap;
    logic           frame_end;
    logic           emit0;
    logic           last0;
    logic [AW-1:0]  addr0;

    // read stage result
    logic                      r_s1_vld;
    logic [AW-1:0]             r_s1_addr;
    logic [1:0]                r_s1_plane;
    logic [rpg_pkg::VAL_W-1:0] r_s1_val;
    logic                      r_s1_last;
    logic                      r_s1_frame;

    // last write, for a read that raced it
    logic                      r_fw_vld;
    logic [AW-1:0]             r_fw_addr;
    logic [rpg_pkg::SUM_W-1:0] r_fw_data;

    logic [rpg_pkg::SUM_W-1:0]  ram_rdata;
    logic [rpg_pkg::SUM_W-1:0]  operand;
    logic [rpg_pkg::TOT_W-1:0]  total;
    logic [rpg_pkg::PROD_W-1:0] prod;
    logic                       wen;
    logic [rpg_pkg::SUM_W-1:0]  wdata;
    logic                       push;
    logic                       pop;
    rpg_pkg::t_res              push_res;

    rpg_pkg::t_res                r_fifo [rpg_pkg::FIFO_DEPTH];
    logic [rpg_pkg::FIFO_AW-1:0]  r_wp;
    logic [rpg_pkg::FIFO_AW-1:0]  r_rp;
    logic [rpg_pkg::FIFO_CW-1:0]  r_cnt;

    assign wh = PRW'(r_w) * PRW'(r_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= clamp_size(rpg_pkg::SIZE_RST, W_MAX);
            r_h <= clamp_size(rpg_pkg::SIZE_RST, H_MAX);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rpg_pkg::CFG_IMAGE_WIDTH:  r_w <= clamp_size(i_cfg_data, W_MAX);
                rpg_pkg::CFG_IMAGE_HEIGHT: r_h <= clamp_size(i_cfg_data, H_MAX);
                default: begin
                end
            endcase
        end
    end

    // twice the plane size: distance from a frame end to the next blue pixel minus one
    always_ff @(posedge i_clk) begin
        r_wh2 <= PW'({wh, 1'b0});
    end

    assign col_inc   = SZW'(r_col) + SZW'(1);
    assign row_inc   = SZW'(r_row) + SZW'(1);
    assign col_wrap  = (col_inc >= r_w);
    assign row_wrap  = (row_inc >= r_h);
    assign emit0     = (r_plane == rpg_pkg::PLANE_BLUE);
    assign frame_end = col_wrap && row_wrap && emit0;
    assign last0     = emit0 && ((i_cmd.rest == '0) ||
                       (frame_end && (CMPW'(i_cmd.rest) <= CMPW'(r_wh2))));
    assign addr0     = AW'(AW'(r_row) * AW'(MAX_WIDTH)) + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= rpg_pkg::PLANE_RED;
        end else if (i_cmd.step) begin
            if (col_wrap) begin
                r_col <= '0;
                if (row_wrap) begin
                    r_row   <= '0;
                    r_plane <= emit0 ? rpg_pkg::PLANE_RED : (r_plane + 2'd1);
                end else begin
                    r_row <= row_inc[RW-1:0];
                end
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= i_run_value;
        end
    end

    rpg_ram #(
        .WIDTH (rpg_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wen),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_raddr (addr0),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.step;
            r_fw_vld <= wen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= addr0;
        r_s1_plane <= r_plane;
        r_s1_val   <= r_val;
        r_s1_last  <= last0;
        r_s1_frame <= frame_end;
        r_fw_addr  <= r_s1_addr;
        r_fw_data  <= wdata;
    end

    assign operand = (r_fw_vld && (r_fw_addr == r_s1_addr)) ? r_fw_data : ram_rdata;
    assign total   = rpg_pkg::TOT_W'(operand) + rpg_pkg::TOT_W'(r_s1_val);
    assign prod    = rpg_pkg::PROD_W'(total) * rpg_pkg::PROD_W'(rpg_pkg::RECIP_3);

    always_comb begin
        case (r_s1_plane)
            rpg_pkg::PLANE_RED:   wdata = rpg_pkg::SUM_W'(r_s1_val);
            rpg_pkg::PLANE_GREEN: wdata = total[rpg_pkg::SUM_W-1:0];
            default:              wdata = operand;
        endcase
    end

    assign wen  = r_s1_vld && (r_s1_plane != rpg_pkg::PLANE_BLUE);
    assign push = r_s1_vld && (r_s1_plane == rpg_pkg::PLANE_BLUE);

    always_comb begin
        push_res.frame_done = r_s1_frame;
        push_res.run_done   = r_s1_last;
        push_res.gray       = prod[rpg_pkg::RECIP_SH +: rpg_pkg::GRAY_W];
    end

    // result fifo
    assign o_res_valid = (r_cnt != '0);
    assign o_res       = r_fifo[r_rp];
    assign pop         = o_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + rpg_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + rpg_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + rpg_pkg::FIFO_CW'(push) - rpg_pkg::FIFO_CW'(pop);
        end
    end

    // room for one more pixel counting the one still in the read stage
    always_comb begin
        o_sts.credit = ((r_cnt + rpg_pkg::FIFO_CW'(push)) <
                        rpg_pkg::FIFO_CW'(rpg_pkg::FIFO_DEPTH));
    end

endmodule

@@ sv/rle_planar_rgb_to_gray.sv @@
// top level of the run-length planar rgb to gray converter
//
// s_axis carries run requests (count, value) covering the red plane, then green,
// then blue, each in raster order. m_axis carries one gray pixel per blue-plane
// pixel: (r + g + b) / 3 truncated; tuser flags the last pixel of a run and tlast
// the last pixel of the frame. A run may cross plane and frame edges.
// The cfg channel writes image_width (index 0) and image_height (index 1); it is
// always ready and must only be used while no run is in flight.
// A run of n pixels (n clamped to MAX_RUN) is stepped one pixel per cycle, while the
// result fifo has room, through a partial-sum ram read-modify-write, and the next
// request is taken only once the run is done; a zero-length run gives nothing.
// The first gray pixel of a run that starts in the blue plane passes the run
// state, the read stage and the result fifo before it is valid.
// Results pass through a 4-entry fifo; when m_axis stalls, pixel stepping pauses
// and s_axis stays not ready until the run is finished.
// Reset clears counters (red plane, origin) and sets both sizes to 512; the
// partial-sum ram is not cleared and needs none, since every entry is written
// in the red plane before it is read.
module rle_planar_rgb_to_gray #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_RUN    = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // run_length[6:0], run_value[14:7]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // gray_level[7:0]
    output logic                          m_axis_tuser,   // run_done[0]
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpg_pkg::CFG_W-1:0]     i_cfg_data
);

    rpg_pkg::t_cmd cmd;
    rpg_pkg::t_sts sts;
    rpg_pkg::t_res res;
    logic          cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    rpg_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_run_length (s_axis_tdata[6:0]),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    rpg_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_run_value (s_axis_tdata[14:7]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = res.gray;
    assign m_axis_tuser = res.run_done;
    assign m_axis_tlast = res.frame_done;

endmodule
